### src/swzs_pkg.sv
// Shared types and constants for the sliding-window z-normalization statistics block.
package swzs_pkg;

	// Register map: index from paddr[3]
	localparam logic REG_WINDOW_LENGTH  = 1'b0;
	localparam logic REG_FLAT_THRESHOLD = 1'b1;

	localparam int LEN_W   = 11;
	localparam int THR_W   = 56;
	localparam int DATA_W  = 64;
	localparam int ADDR_W  = 4;
	localparam int IN_W    = 24;
	localparam int IDX_W   = 24;
	localparam int MEAN_W  = 32;
	localparam int INV_W   = 32;
	localparam int DF_W    = 25;
	localparam int DG_W    = 34;

	localparam logic [LEN_W-1:0] WINDOW_LENGTH_RESET = 11'd16;

	// Configuration seen by the front and back parts
	typedef struct packed {
		logic [LEN_W-1:0] window_length;
		logic [THR_W-1:0] flat_threshold;
	} cfg_t;

	// Queue status
	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

### src/sliding_window_znorm_stats_unit.sv
// Sliding-window z-normalization statistics unit: top level with register port.
//
// Input channel (in_valid/in_stall) takes one sample word with its non-finite
// and series-start flags. Output channel (out_valid/out_stall) gives one word
// per completed window: index, mean, inverse norm, invalid flag and the df/dg
// deltas of the previous window. A word moves when valid is high and stall low.
// The front part accepts a sample with a ring read, then updates the sums, and
// adds a push state when the sample completes a window and a job is pushed;
// in_stall stays high until it is back in idle. Samples that do not complete a
// window produce no word. The back part runs a shared 64-step restoring divider
// twice, then, unless the window is invalid or its deviation sum is below two, a
// third time and then a 32-step root loop. A two-entry queue sits between the
// parts; the output register lets the back part work on the next window while
// a word waits. Registers: window_length at 0x0, flat_threshold at 0x8 (64-bit
// data). Writing window_length clears the running series state. Reset clears
// all control state; the sample ring is only read after being written, so it
// needs no clearing pass. While out_stall is high the result word holds and the
// queue fills, after which the front part holds in_stall high.
module sliding_window_znorm_stats_unit #(
	parameter int MAX_WINDOW  = 1024,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [swzs_pkg::ADDR_W-1:0]       paddr,
	input  logic [swzs_pkg::DATA_W-1:0]       pwdata,
	output logic [swzs_pkg::DATA_W-1:0]       prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [swzs_pkg::IN_W-1:0]  sample,
	input  logic                              not_finite,
	input  logic                              series_start,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [swzs_pkg::IDX_W-1:0]        window_index,
	output logic signed [swzs_pkg::MEAN_W-1:0] window_mean,
	output logic [swzs_pkg::INV_W-1:0]        inverse_norm,
	output logic                              invalid,
	output logic signed [swzs_pkg::DF_W-1:0]  prev_df,
	output logic signed [swzs_pkg::DG_W-1:0]  prev_dg,
	output logic                              prev_valid
);
	localparam int LB    = $clog2(MAX_WINDOW + 1);
	localparam int JOB_W = swzs_pkg::IDX_W + LB + 2 + 2 * SAMPLE_BITS
		+ (SAMPLE_BITS + LB) + (2 * SAMPLE_BITS + LB);

	swzs_pkg::cfg_t       cfg_q;
	swzs_pkg::fifo_stat_t fstat;
	logic                 wr_en;
	logic                 clear_series;
	logic                 push;
	logic                 pop;
	logic [JOB_W-1:0]     push_data;
	logic [JOB_W-1:0]     pop_data;

	assign pready       = 1'b1;
	assign wr_en        = psel && penable && pwrite;
	assign clear_series = wr_en && (paddr[3] == swzs_pkg::REG_WINDOW_LENGTH);

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_length  <= swzs_pkg::WINDOW_LENGTH_RESET;
			cfg_q.flat_threshold <= '0;
		end else if (wr_en) begin
			if (paddr[3] == swzs_pkg::REG_WINDOW_LENGTH) begin
				cfg_q.window_length <= pwdata[swzs_pkg::LEN_W-1:0];
			end else begin
				cfg_q.flat_threshold <= pwdata[swzs_pkg::THR_W-1:0];
			end
		end
	end

	// Register reads
	always_comb begin
		if (paddr[3] == swzs_pkg::REG_WINDOW_LENGTH) begin
			prdata = swzs_pkg::DATA_W'(cfg_q.window_length);
		end else begin
			prdata = swzs_pkg::DATA_W'(cfg_q.flat_threshold);
		end
	end

	swzs_front #(
		.MAX_WINDOW  (MAX_WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.clear_series (clear_series),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample       (sample),
		.not_finite   (not_finite),
		.series_start (series_start),
		.fstat        (fstat),
		.push         (push),
		.push_data    (push_data)
	);

	swzs_fifo #(
		.WIDTH (JOB_W),
		.DEPTH (2)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (fstat)
	);

	swzs_back #(
		.MAX_WINDOW  (MAX_WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.bstat        (fstat),
		.pop          (pop),
		.pop_data     (pop_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.window_index (window_index),
		.window_mean  (window_mean),
		.inverse_norm (inverse_norm),
		.invalid      (invalid),
		.prev_df      (prev_df),
		.prev_dg      (prev_dg),
		.prev_valid   (prev_valid)
	);
endmodule

### src/swzs_fifo.sv
// Short job queue between the front and back parts.
module swzs_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  logic [WIDTH-1:0]        push_data,
	input  logic                    pop,
	output logic [WIDTH-1:0]        pop_data,
	output swzs_pkg::fifo_stat_t    stat
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;

	assign stat.full  = (cnt_q == CW'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign pop_data   = mem_q[rd_q];

	// Store the pushed word
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		stat.full |-> !push || pop)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		stat.empty |-> !pop)
		else $error("pop from empty queue");
	a_count_push: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("fill count did not follow push");
endmodule

### src/swzs_front.sv
// Front part: takes samples, keeps the ring and exact running sums, queues window jobs.
module swzs_front #(
	parameter int MAX_WINDOW  = 1024,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  swzs_pkg::cfg_t             cfg,
	input  logic                       clear_series,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [swzs_pkg::IN_W-1:0]  sample,
	input  logic                       not_finite,
	input  logic                       series_start,
	input  swzs_pkg::fifo_stat_t       fstat,
	output logic                       push,
	output logic [swzs_pkg::IDX_W+$clog2(MAX_WINDOW+1)+2+2*SAMPLE_BITS
		+(SAMPLE_BITS+$clog2(MAX_WINDOW+1))+(2*SAMPLE_BITS+$clog2(MAX_WINDOW+1))-1:0]
		push_data
);
	localparam int SB   = SAMPLE_BITS;
	localparam int LB   = $clog2(MAX_WINDOW + 1);
	localparam int PB   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int SUMW = SB + LB;
	localparam int SQW  = 2 * SB + LB;

	typedef enum logic [1:0] {F_IDLE, F_READ, F_PUSH} fstate_t;

	fstate_t                 state_q;
	logic signed [SB-1:0]    ring_q [MAX_WINDOW];
	logic signed [SB-1:0]    rd_data_q;
	logic [PB-1:0]           ptr_q;
	logic signed [SUMW-1:0]  sum_q;
	logic [SQW-1:0]          sq_q;
	logic [LB-1:0]           seen_q;
	logic [LB-1:0]           ssb_q;
	logic [swzs_pkg::IDX_W-1:0] win_q;
	logic signed [SB-1:0]    x_q;
	logic signed [SB-1:0]    dr_q;
	logic                    nan_q;
	logic                    had_q;

	logic [LB-1:0]           m;
	logic                    accept;
	logic [PB-1:0]           ptr_b;
	logic [PB-1:0]           ptr_e;
	logic [LB-1:0]           ssb_b;
	logic                    nan_w;
	logic signed [SB-1:0]    x_in;
	logic                    had_w;
	logic signed [SB-1:0]    dr_w;
	logic signed [2*SB-1:0]  xx;
	logic signed [2*SB-1:0]  dd;
	logic [LB-1:0]           seen_n;
	logic [LB-1:0]           ptr_inc;

	// Clamp the window length to the supported range
	always_comb begin
		if (cfg.window_length < swzs_pkg::LEN_W'(2)) begin
			m = LB'(2);
		end else if (32'(cfg.window_length) > MAX_WINDOW) begin
			m = LB'(MAX_WINDOW);
		end else begin
			m = LB'(cfg.window_length);
		end
	end

	assign in_stall = (state_q != F_IDLE);
	assign accept   = in_valid && (state_q == F_IDLE);

	// Classify the incoming word
	always_comb begin
		ptr_b = series_start ? '0 : ptr_q;
		ptr_e = (LB'(ptr_b) >= m) ? '0 : ptr_b;
		ssb_b = series_start ? '1 : ssb_q;
		if (not_finite) begin
			ssb_b = '0;
		end
		nan_w = (ssb_b < m);
		x_in  = not_finite ? '0 : $signed(sample[SB-1:0]);
	end

	// Drop the oldest sample once the window is full
	always_comb begin
		had_w   = (seen_q >= m);
		dr_w    = had_w ? rd_data_q : '0;
		xx      = x_q * x_q;
		dd      = dr_w * dr_w;
		seen_n  = had_w ? seen_q : seen_q + 1'b1;
		ptr_inc = LB'(ptr_q) + 1'b1;
	end

	assign push      = (state_q == F_PUSH) && !fstat.full;
	assign push_data = {win_q, m, nan_q, had_q, x_q, dr_q, sum_q, sq_q};

	// Ring memory
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_data_q <= ring_q[ptr_e];
		end
		if (state_q == F_READ) begin
			ring_q[ptr_q] <= x_q;
		end
	end

	// Sequence one sample and hold the running state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			ptr_q   <= '0;
			sum_q   <= '0;
			sq_q    <= '0;
			seen_q  <= '0;
			ssb_q   <= '1;
			win_q   <= '0;
			nan_q   <= 1'b0;
			had_q   <= 1'b0;
			x_q     <= '0;
			dr_q    <= '0;
		end else if (clear_series) begin
			state_q <= F_IDLE;
			ptr_q   <= '0;
			sum_q   <= '0;
			sq_q    <= '0;
			seen_q  <= '0;
			ssb_q   <= '1;
			win_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						if (series_start) begin
							sum_q  <= '0;
							sq_q   <= '0;
							seen_q <= '0;
							win_q  <= '0;
						end
						ptr_q   <= ptr_e;
						ssb_q   <= nan_w ? ssb_b + 1'b1 : ssb_b;
						nan_q   <= nan_w;
						x_q     <= x_in;
						state_q <= F_READ;
					end
				end
				F_READ: begin
					sum_q   <= sum_q + SUMW'(x_q) - SUMW'(dr_w);
					sq_q    <= sq_q + SQW'($unsigned(xx)) - SQW'($unsigned(dd));
					ptr_q   <= (ptr_inc >= m) ? '0 : PB'(ptr_inc);
					seen_q  <= seen_n;
					had_q   <= had_w;
					dr_q    <= dr_w;
					state_q <= (seen_n >= m) ? F_PUSH : F_IDLE;
				end
				F_PUSH: begin
					if (!fstat.full) begin
						win_q   <= win_q + 1'b1;
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end
endmodule

### src/swzs_back.sv
// Back part: mean, exact deviation sum, inverse root and deltas, with output register.
module swzs_back #(
	parameter int MAX_WINDOW  = 1024,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  swzs_pkg::cfg_t                cfg,
	input  swzs_pkg::fifo_stat_t          bstat,
	output logic                          pop,
	input  logic [swzs_pkg::IDX_W+$clog2(MAX_WINDOW+1)+2+2*SAMPLE_BITS
		+(SAMPLE_BITS+$clog2(MAX_WINDOW+1))+(2*SAMPLE_BITS+$clog2(MAX_WINDOW+1))-1:0]
		pop_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [swzs_pkg::IDX_W-1:0]    window_index,
	output logic signed [swzs_pkg::MEAN_W-1:0] window_mean,
	output logic [swzs_pkg::INV_W-1:0]    inverse_norm,
	output logic                          invalid,
	output logic signed [swzs_pkg::DF_W-1:0] prev_df,
	output logic signed [swzs_pkg::DG_W-1:0] prev_dg,
	output logic                          prev_valid
);
	localparam int SB   = SAMPLE_BITS;
	localparam int LB   = $clog2(MAX_WINDOW + 1);
	localparam int SUMW = SB + LB;
	localparam int SQW  = 2 * SB + LB;
	localparam int DGW  = swzs_pkg::DG_W;

	typedef enum logic [3:0] {
		B_IDLE, B_DIV1, B_MUL1, B_MUL2, B_DIV2, B_DEV, B_DIV3, B_ROOT, B_OUT
	} bstate_t;

	// Job fields
	logic [swzs_pkg::IDX_W-1:0] j_win;
	logic [LB-1:0]              j_m;
	logic                       j_nan;
	logic                       j_had;
	logic signed [SB-1:0]       j_x;
	logic signed [SB-1:0]       j_dr;
	logic signed [SUMW-1:0]     j_sum;
	logic [SQW-1:0]             j_sq;
	logic [SUMW-1:0]            a_abs;

	assign {j_win, j_m, j_nan, j_had, j_x, j_dr, j_sum, j_sq} = pop_data;
	assign a_abs = j_sum[SUMW-1] ? SUMW'(-j_sum) : SUMW'(j_sum);

	bstate_t                    state_q;
	logic [swzs_pkg::IDX_W-1:0] win_q;
	logic [LB-1:0]              m_q;
	logic                       nan_q;
	logic                       had_q;
	logic                       neg_q;
	logic signed [SB-1:0]       x_q;
	logic signed [SB-1:0]       dr_q;
	logic [SQW-1:0]             sq_q;

	logic [63:0]                dvd_q;
	logic [63:0]                dsr_q;
	logic [63:0]                rem_q;
	logic [63:0]                quo_q;
	logic [5:0]                 cnt_q;

	logic [LB-1:0]              r_q;
	logic [SB+7:0]              mq_q;
	logic [2*SB-1:0]            qq_q;
	logic [SB+LB-1:0]           qr_q;
	logic [2*LB-1:0]            rr_q;
	logic signed [SB+8:0]       mean_q;
	logic [63:0]                mqq_q;
	logic [63:0]                fsq_q;
	logic                       exact_q;
	logic                       inval_q;
	logic [31:0]                inv_q;
	logic [63:0]                rx_q;
	logic [63:0]                res_q;
	logic [63:0]                bit_q;
	logic signed [DGW-1:0]      prevm_q;

	logic                       out_valid_q;
	logic [swzs_pkg::IDX_W-1:0] idx_o_q;
	logic signed [swzs_pkg::MEAN_W-1:0] mean_o_q;
	logic [swzs_pkg::INV_W-1:0] inv_o_q;
	logic                       inval_o_q;
	logic signed [swzs_pkg::DF_W-1:0] df_o_q;
	logic signed [DGW-1:0]      dg_o_q;
	logic                       pv_o_q;

	// One restoring division step
	logic [64:0] rem_sh;
	logic        ge;
	logic [63:0] rem_n;
	logic [63:0] quo_n;

	always_comb begin
		rem_sh = {rem_q, dvd_q[63]};
		ge     = (rem_sh >= {1'b0, dsr_q});
		rem_n  = ge ? 64'(rem_sh - {1'b0, dsr_q}) : rem_sh[63:0];
		quo_n  = {quo_q[62:0], ge};
	end

	// Products, deviation and root step
	logic [SB-1:0]   q_w;
	logic [63:0]     ceil_w;
	logic [63:0]     sq64;
	logic [63:0]     dev_w;
	logic [63:0]     thr64;
	logic            flat_w;
	logic [63:0]     rt_w;
	logic            rge;
	logic [63:0]     res_n;
	logic signed [DGW-1:0] xs_w;
	logic signed [DGW-1:0] ds_w;
	logic signed [DGW-1:0] dg_w;
	logic signed [swzs_pkg::DF_W-1:0] df_w;
	logic            load_out;

	always_comb begin
		q_w    = mq_q[SB+7:8];
		sq64   = 64'(sq_q);
		ceil_w = fsq_q + {63'b0, !exact_q};
		dev_w  = (sq64 > ceil_w) ? sq64 - ceil_w : '0;
		thr64  = 64'(cfg.flat_threshold);
		flat_w = (dev_w < thr64) || ((dev_w == thr64) && exact_q);
		rt_w   = res_q + bit_q;
		rge    = (rx_q >= rt_w);
		res_n  = rge ? (res_q >> 1) + bit_q : (res_q >> 1);
		xs_w   = DGW'(x_q) <<< 8;
		ds_w   = DGW'(dr_q) <<< 8;
		dg_w   = xs_w - DGW'(mean_q) + ds_w - prevm_q;
		df_w   = swzs_pkg::DF_W'(x_q) - swzs_pkg::DF_W'(dr_q);
	end

	assign pop      = (state_q == B_IDLE) && !bstat.empty;
	assign load_out = (state_q == B_OUT) && (!out_valid_q || !out_stall);

	assign out_valid    = out_valid_q;
	assign window_index = idx_o_q;
	assign window_mean  = mean_o_q;
	assign inverse_norm = inv_o_q;
	assign invalid      = inval_o_q;
	assign prev_df      = df_o_q;
	assign prev_dg      = dg_o_q;
	assign prev_valid   = pv_o_q;

	// Sequence one window job and hold the result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (pop) begin
						win_q   <= j_win;
						m_q     <= j_m;
						nan_q   <= j_nan;
						had_q   <= j_had;
						neg_q   <= j_sum[SUMW-1];
						x_q     <= j_x;
						dr_q    <= j_dr;
						sq_q    <= j_sq;
						dvd_q   <= 64'(a_abs) << 8;
						dsr_q   <= 64'(j_m);
						rem_q   <= '0;
						quo_q   <= '0;
						cnt_q   <= '0;
						state_q <= B_DIV1;
					end
				end
				B_DIV1: begin
					dvd_q <= dvd_q << 1;
					rem_q <= rem_n;
					quo_q <= quo_n;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 6'd55) begin
						r_q <= rem_n[LB-1:0];
					end
					if (cnt_q == 6'd63) begin
						mq_q    <= quo_n[SB+7:0];
						state_q <= B_MUL1;
					end
				end
				B_MUL1: begin
					qq_q    <= q_w * q_w;
					qr_q    <= q_w * r_q;
					rr_q    <= r_q * r_q;
					mean_q  <= neg_q ? -$signed({1'b0, mq_q}) : $signed({1'b0, mq_q});
					state_q <= B_MUL2;
				end
				B_MUL2: begin
					mqq_q   <= 64'(m_q * qq_q);
					dvd_q   <= 64'(rr_q);
					dsr_q   <= 64'(m_q);
					rem_q   <= '0;
					quo_q   <= '0;
					cnt_q   <= '0;
					state_q <= B_DIV2;
				end
				B_DIV2: begin
					dvd_q <= dvd_q << 1;
					rem_q <= rem_n;
					quo_q <= quo_n;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 6'd63) begin
						fsq_q   <= mqq_q + (64'(qr_q) << 1) + quo_n;
						exact_q <= (rem_n == '0);
						state_q <= B_DEV;
					end
				end
				B_DEV: begin
					inval_q <= nan_q || flat_w;
					if (nan_q || flat_w) begin
						inv_q   <= '0;
						state_q <= B_OUT;
					end else if (dev_w < 64'd2) begin
						inv_q   <= '1;
						state_q <= B_OUT;
					end else begin
						dvd_q   <= '1;
						dsr_q   <= dev_w;
						rem_q   <= '0;
						quo_q   <= '0;
						cnt_q   <= '0;
						state_q <= B_DIV3;
					end
				end
				B_DIV3: begin
					dvd_q <= dvd_q << 1;
					rem_q <= rem_n;
					quo_q <= quo_n;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 6'd63) begin
						rx_q    <= quo_n + {63'b0, (rem_n == dsr_q - 64'd1)};
						res_q   <= '0;
						bit_q   <= 64'h4000_0000_0000_0000;
						cnt_q   <= '0;
						state_q <= B_ROOT;
					end
				end
				B_ROOT: begin
					if (rge) begin
						rx_q <= rx_q - rt_w;
					end
					res_q <= res_n;
					bit_q <= bit_q >> 2;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 6'd31) begin
						inv_q   <= (res_n[63:32] != '0) ? '1 : res_n[31:0];
						state_q <= B_OUT;
					end
				end
				B_OUT: begin
					if (load_out) begin
						out_valid_q <= 1'b1;
						idx_o_q     <= win_q;
						mean_o_q    <= swzs_pkg::MEAN_W'(mean_q);
						inv_o_q     <= inv_q;
						inval_o_q   <= inval_q;
						df_o_q      <= had_q ? df_w : '0;
						dg_o_q      <= had_q ? dg_w : '0;
						pv_o_q      <= had_q;
						prevm_q     <= DGW'(mean_q);
						state_q     <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end
endmodule

### test/tb_top.sv
// Self-checking testbench for the sliding-window z-normalization statistics unit.
module tb_top;

	localparam int HALF_PERIOD = 4;
	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 1000;
	localparam int RING_DEPTH = 1024;

	typedef struct {
		logic [swzs_pkg::IDX_W-1:0]         idx;
		logic signed [swzs_pkg::MEAN_W-1:0] mean;
		logic [swzs_pkg::INV_W-1:0]         inv;
		logic                               bad;
		logic signed [swzs_pkg::DF_W-1:0]   df;
		logic signed [swzs_pkg::DG_W-1:0]   dg;
		logic                               pv;
	} window_word_t;

	logic                               clk;
	logic                               arst_n;
	logic                               psel, penable, pwrite;
	logic [swzs_pkg::ADDR_W-1:0]        paddr;
	logic [swzs_pkg::DATA_W-1:0]        pwdata;
	logic [swzs_pkg::DATA_W-1:0]        prdata;
	logic                               pready;
	logic                               in_valid, in_stall;
	logic signed [swzs_pkg::IN_W-1:0]   sample;
	logic                               not_finite, series_start;
	logic                               out_valid, out_stall;
	logic [swzs_pkg::IDX_W-1:0]         window_index;
	logic signed [swzs_pkg::MEAN_W-1:0] window_mean;
	logic [swzs_pkg::INV_W-1:0]         inverse_norm;
	logic                               invalid;
	logic signed [swzs_pkg::DF_W-1:0]   prev_df;
	logic signed [swzs_pkg::DG_W-1:0]   prev_dg;
	logic                               prev_valid;

	// Shadow of the block's state
	longint      ring_mem [RING_DEPTH];
	int          wr_ptr, fill_cnt, clean_run;
	longint      sum_acc, last_mean;
	bit [63:0]   sq_acc;
	bit [23:0]   win_cnt;
	bit [10:0]   len_reg;
	bit [55:0]   thr_reg;

	window_word_t stats_q[$];
	int           fail_cnt;
	int           samples_taken;
	int           idle_cycles;
	bit           quiet;

	sliding_window_znorm_stats_unit dut (.*);

	always begin
		clk = 1'b0;
		#HALF_PERIOD;
		clk = 1'b1;
		#HALF_PERIOD;
	end

	function automatic int eff_len();
		if (len_reg < 2) return 2;
		if (len_reg > RING_DEPTH) return RING_DEPTH;
		return int'(len_reg);
	endfunction

	function automatic void clear_series();
		wr_ptr = 0;
		sum_acc = 0;
		sq_acc = 0;
		fill_cnt = 0;
		clean_run = eff_len();
		last_mean = 0;
		win_cnt = 0;
	endfunction

	function automatic bit [63:0] isqrt64(bit [63:0] x);
		bit [63:0] res, b;
		res = 0;
		b = 64'h1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic bit [63:0] inv_root(bit [63:0] d);
		bit [63:0] q;
		if (d < 2) return 64'hFFFF_FFFF;
		q = 64'hFFFF_FFFF_FFFF_FFFF / d;
		if ((64'hFFFF_FFFF_FFFF_FFFF % d) == d - 1) q += 1;
		q = isqrt64(q);
		return (q > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : q;
	endfunction

	// Advance the shadow state by one word; queue a window word when one completes
	function automatic void predict_window(logic signed [swzs_pkg::IN_W-1:0] s, logic nf,
	                                       logic ss);
		int           m;
		bit           nan_win, had_prev, flat;
		longint       x, dropped, mean, df, dg;
		bit [63:0]    a, q, r, rr, m64, floor_sq, ceil_sq, dev, inv;
		window_word_t w;
		m = eff_len();
		x = nf ? 0 : longint'(s);
		dropped = 0;
		had_prev = 0;
		df = 0;
		dg = 0;
		if (ss) clear_series();
		if (nf) clean_run = 0;
		nan_win = clean_run < m;
		if (clean_run < m) clean_run++;
		if (wr_ptr >= m) wr_ptr = 0;
		if (fill_cnt >= m) begin
			dropped = ring_mem[wr_ptr];
			sum_acc -= dropped;
			sq_acc -= 64'(dropped * dropped);
			had_prev = 1;
		end
		ring_mem[wr_ptr] = x;
		wr_ptr = (wr_ptr + 1 >= m) ? 0 : wr_ptr + 1;
		sum_acc += x;
		sq_acc += 64'(x * x);
		if (fill_cnt < m) fill_cnt++;
		if (fill_cnt < m) return;
		mean = (sum_acc * 256) / longint'(m);
		// exact deviation sum from sum = m*q + r
		m64 = 64'(m);
		a = (sum_acc < 0) ? 64'(-sum_acc) : 64'(sum_acc);
		q = a / m64;
		r = a % m64;
		rr = r * r;
		floor_sq = m64 * q * q + 2 * q * r + rr / m64;
		ceil_sq = floor_sq + (((rr % m64) != 0) ? 64'd1 : 64'd0);
		dev = (sq_acc > ceil_sq) ? sq_acc - ceil_sq : 64'd0;
		flat = (dev < 64'(thr_reg)) || (dev == 64'(thr_reg) && (rr % m64) == 0);
		inv = (nan_win || flat) ? 64'd0 : inv_root(dev);
		if (had_prev) begin
			df = x - dropped;
			dg = (x * 256 - mean) + (dropped * 256 - last_mean);
		end
		w.idx = win_cnt;
		w.mean = mean[swzs_pkg::MEAN_W-1:0];
		w.inv = inv[swzs_pkg::INV_W-1:0];
		w.bad = nan_win || flat;
		w.df = df[swzs_pkg::DF_W-1:0];
		w.dg = dg[swzs_pkg::DG_W-1:0];
		w.pv = had_prev;
		stats_q.insert(stats_q.size(), w);
		last_mean = mean;
		win_cnt = win_cnt + 1;
	endfunction

	task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_v, act_v);
			fail_cnt++;
		end
	endtask

	// Take accepted input words and check accepted output words
	always @(posedge clk) begin
		window_word_t w;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_window(sample, not_finite, series_start);
				samples_taken++;
			end
			if (out_valid && !out_stall) begin
				if (stats_q.size() == 0) begin
					$display("%0t: unexpected window word, expected none, got index %0h",
					         $time, window_index);
					fail_cnt++;
				end else begin
					w = stats_q.pop_front();
					check_field("window_index", 64'(w.idx), 64'(window_index));
					check_field("window_mean", 64'(w.mean), 64'(window_mean));
					check_field("inverse_norm", 64'(w.inv), 64'(inverse_norm));
					check_field("invalid", 64'(w.bad), 64'(invalid));
					check_field("prev_df", 64'(w.df), 64'(prev_df));
					check_field("prev_dg", 64'(w.dg), 64'(prev_dg));
					check_field("prev_valid", 64'(w.pv), 64'(prev_valid));
				end
			end
			// Watchdog on cycles with no word moving
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("sliding_window_znorm_stats_unit test failed");
				$finish;
			end
		end
	end

	// Receiver stalls in random bursts
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 11)) @(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	task automatic send_sample(logic signed [swzs_pkg::IN_W-1:0] s, logic nf, logic ss);
		int n0;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		sample = s;
		not_finite = nf;
		series_start = ss;
		in_valid = 1'b1;
		n0 = samples_taken;
		do @(negedge clk); while (samples_taken == n0);
		in_valid = 1'b0;
	endtask

	// Let every expected word arrive, then let the pipeline empty
	task automatic wait_idle();
		while (stats_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic reg_write(logic idx, logic [swzs_pkg::DATA_W-1:0] value);
		wait_idle();
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = swzs_pkg::ADDR_W'(idx) << 3;
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		if (idx == swzs_pkg::REG_WINDOW_LENGTH) begin
			len_reg = value[swzs_pkg::LEN_W-1:0];
			clear_series();
		end else begin
			thr_reg = value[swzs_pkg::THR_W-1:0];
		end
	endtask

	function automatic logic signed [swzs_pkg::IN_W-1:0] rand_sample(bit tiny);
		if (tiny) return swzs_pkg::IN_W'($signed($urandom_range(0, 8)) - 4);
		return swzs_pkg::IN_W'($urandom);
	endfunction

	// Extremes of the sample, non-finite words, series start and a threshold sweep
	task automatic test_directed();
		reg_write(swzs_pkg::REG_WINDOW_LENGTH, 64'd2);
		reg_write(swzs_pkg::REG_FLAT_THRESHOLD, 64'd0);
		send_sample(24'sh7FFFFF, 1'b0, 1'b0);
		send_sample(-24'sh800000, 1'b0, 1'b0);
		send_sample(-24'sh800000, 1'b0, 1'b0);
		send_sample(24'sh7FFFFF, 1'b0, 1'b0);
		send_sample(24'sh7FFFFF, 1'b0, 1'b0);
		send_sample(24'sh000005, 1'b1, 1'b0);
		send_sample(24'sh000003, 1'b0, 1'b0);
		send_sample(24'sh000003, 1'b0, 1'b0);
		send_sample(24'sh000004, 1'b0, 1'b0);
		send_sample(24'sh000000, 1'b0, 1'b1);
		send_sample(24'sh000001, 1'b0, 1'b0);
		send_sample(-24'sh000001, 1'b0, 1'b0);
		reg_write(swzs_pkg::REG_FLAT_THRESHOLD, 64'h00FF_FFFF_FFFF_FFFF);
		send_sample(24'sh123456, 1'b0, 1'b0);
		send_sample(-24'sh654321, 1'b0, 1'b0);
		reg_write(swzs_pkg::REG_FLAT_THRESHOLD, 64'd2);
		reg_write(swzs_pkg::REG_WINDOW_LENGTH, 64'd3);
		send_sample(24'sh000001, 1'b0, 1'b0);
		send_sample(24'sh000002, 1'b0, 1'b0);
		send_sample(24'sh000003, 1'b0, 1'b0);
		send_sample(24'sh000004, 1'b0, 1'b0);
		send_sample(24'sh000006, 1'b0, 1'b0);
	endtask

	// Lengths below two and above the ring depth
	task automatic test_length_limits();
		int n;
		reg_write(swzs_pkg::REG_FLAT_THRESHOLD, 64'd0);
		reg_write(swzs_pkg::REG_WINDOW_LENGTH, 64'd0);
		for (n = 0; n < 6; n++) send_sample(rand_sample(0), 1'b0, 1'b0);
		reg_write(swzs_pkg::REG_WINDOW_LENGTH, 64'd1);
		for (n = 0; n < 6; n++) send_sample(rand_sample(0), n == 2, 1'b0);
		reg_write(swzs_pkg::REG_WINDOW_LENGTH, 64'h7FF);
		for (n = 0; n < 40; n++) send_sample(rand_sample(0), n == 3, 1'b0);
	endtask

	// Random phases: mostly long series with occasional restarts and bad words
	task automatic test_random();
		int phase, n, len, items;
		bit tiny;
		for (phase = 0; phase < 7; phase++) begin
			if (phase == 6) quiet = 1'b1;
			case ($urandom_range(0, 3))
				0: len = 2;
				1: len = $urandom_range(3, 6);
				2: len = $urandom_range(7, 20);
				default: len = $urandom_range(21, 64);
			endcase
			reg_write(swzs_pkg::REG_WINDOW_LENGTH, 64'(len));
			case ($urandom_range(0, 3))
				0: reg_write(swzs_pkg::REG_FLAT_THRESHOLD, 64'd0);
				1: reg_write(swzs_pkg::REG_FLAT_THRESHOLD, 64'($urandom_range(0, 40)));
				2: reg_write(swzs_pkg::REG_FLAT_THRESHOLD,
				             {$urandom, $urandom} >> $urandom_range(8, 40));
				default: reg_write(swzs_pkg::REG_FLAT_THRESHOLD,
				                   {8'h00, 24'($urandom_range(0, 255)), $urandom});
			endcase
			tiny = $urandom_range(0, 2) == 0;
			items = 55;
			for (n = 0; n < items; n++) begin
				send_sample(rand_sample(tiny), $urandom_range(0, 15) == 0,
				            $urandom_range(0, 24) == 0);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		sample = '0;
		not_finite = 1'b0;
		series_start = 1'b0;
		quiet = 1'b0;
		fail_cnt = 0;
		samples_taken = 0;
		idle_cycles = 0;
		len_reg = swzs_pkg::WINDOW_LENGTH_RESET;
		thr_reg = '0;
		clear_series();
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_length_limits();
		test_random();
		wait_idle();
		if (fail_cnt == 0) begin
			$display("sliding_window_znorm_stats_unit test passed");
		end else begin
			$display("sliding_window_znorm_stats_unit test failed");
		end
		$finish;
	end

endmodule

### filelist.f
src/swzs_pkg.sv
src/swzs_fifo.sv
src/swzs_front.sv
src/swzs_back.sv
src/sliding_window_znorm_stats_unit.sv
test/tb_top.sv
